// File: hdl/pim_pkg.sv
// ----------------------------------------------------------------------------
// pim_pkg
// Shared types and defaults of the priority inheritance mutex.
// ----------------------------------------------------------------------------
package pim_pkg;

    localparam int MAX_WAITERS_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int PRIO_BITS_DEF   = 8;

    typedef enum logic [1:0] {
        KIND_LOCK    = 2'd0,
        KIND_TRYLOCK = 2'd1,
        KIND_UNLOCK  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        OUT_ACQUIRED    = 3'd0,
        OUT_QUEUED      = 3'd1,
        OUT_QUEUE_FULL  = 3'd2,
        OUT_TRY_FAILED  = 3'd3,
        OUT_HANDED_OVER = 3'd4,
        OUT_FREED       = 3'd5
    } t_outcome;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET_LAST,
        S_REPLACE,
        S_SCAN,
        S_FINISH,
        S_HOLD
    } t_state;

    // Update commands for the top waiter tracker.
    typedef struct packed {
        logic take_any;
        logic take_max;
    } t_find_ctl;

endpackage

// File: hdl/pim_waiter_ram.sv
// ----------------------------------------------------------------------------
// pim_waiter_ram
// Waiter table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pim_waiter_ram #(
    parameter int WIDTH = pim_pkg::ID_BITS_DEF + pim_pkg::PRIO_BITS_DEF,
    parameter int DEPTH = pim_pkg::MAX_WAITERS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/pim_top_finder.sv
// ----------------------------------------------------------------------------
// pim_top_finder
// Tracks the index and priority of the highest waiter in the table.
// ----------------------------------------------------------------------------
module pim_top_finder #(
    parameter int MAX_WAITERS = pim_pkg::MAX_WAITERS_DEF,
    parameter int PRIO_BITS   = pim_pkg::PRIO_BITS_DEF
) (
    input  logic                           i_clk,
    input  pim_pkg::t_find_ctl             i_ctl,
    input  logic [$clog2(MAX_WAITERS)-1:0] i_idx,
    input  logic [PRIO_BITS-1:0]           i_prio,
    output logic [$clog2(MAX_WAITERS)-1:0] o_top_idx,
    output logic [PRIO_BITS-1:0]           o_top_prio,
    output logic [PRIO_BITS-1:0]           o_next_prio
);

    localparam int IDX_W = $clog2(MAX_WAITERS);

    logic [IDX_W-1:0]     r_top_idx;
    logic [PRIO_BITS-1:0] r_top_prio;
    logic [IDX_W-1:0]     n_top_idx;
    logic [PRIO_BITS-1:0] n_top_prio;

    // A candidate wins only when strictly higher, so the lowest index keeps ties.
    always_comb begin
        n_top_idx  = r_top_idx;
        n_top_prio = r_top_prio;
        if (i_ctl.take_any || (i_ctl.take_max && (i_prio > r_top_prio))) begin
            n_top_idx  = i_idx;
            n_top_prio = i_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_idx  <= n_top_idx;
        r_top_prio <= n_top_prio;
    end

    assign o_top_idx   = r_top_idx;
    assign o_top_prio  = r_top_prio;
    assign o_next_prio = n_top_prio;

endmodule

// File: hdl/priority_inheritance_mutex.sv
// ----------------------------------------------------------------------------
// priority_inheritance_mutex
// Mutex with priority inheritance: lock, trylock and unlock requests, one
// result per request of those kinds, waiters held in a table memory.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake                 | Payload
// input   | in        | i_in_valid / o_in_ready   | kind, task_id, task_priority
// output  | out       | o_out_valid / i_out_ready | outcome, restore, boost, grant
//
// Lock, trylock and unlock of a free mutex finish in the idle state; unknown
// kinds get no result. Unlock that hands over to the only waiter goes through
// GET_LAST and REPLACE. Unlock with waiters left does two table reads for the
// swap-remove, a table rescan via its single read port, then the boost check.
// A result waits in the output register while the next request is taken.
// Reset is synchronous and clears the owner, the waiter count and the handshake state.
// An output stall only holds the block once a second result is ready.
// ----------------------------------------------------------------------------
module priority_inheritance_mutex #(
    parameter int MAX_WAITERS = pim_pkg::MAX_WAITERS_DEF,
    parameter int ID_BITS     = pim_pkg::ID_BITS_DEF,
    parameter int PRIO_BITS   = pim_pkg::PRIO_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_kind,
    input  logic [ID_BITS-1:0]   i_task_id,
    input  logic [PRIO_BITS-1:0] i_task_priority,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_outcome,
    output logic                 o_restore_valid,
    output logic [ID_BITS-1:0]   o_restore_task,
    output logic [PRIO_BITS-1:0] o_restore_priority,
    output logic                 o_boost_valid,
    output logic [ID_BITS-1:0]   o_boost_task,
    output logic [PRIO_BITS-1:0] o_boost_priority,
    output logic                 o_grant_valid,
    output logic [ID_BITS-1:0]   o_grant_task
);

    localparam int IDX_W = $clog2(MAX_WAITERS);
    localparam int CNT_W = $clog2(MAX_WAITERS + 1);
    localparam int ENT_W = ID_BITS + PRIO_BITS;

    typedef struct packed {
        pim_pkg::t_outcome    outcome;
        logic                 restore_valid;
        logic [ID_BITS-1:0]   restore_task;
        logic [PRIO_BITS-1:0] restore_priority;
        logic                 boost_valid;
        logic [ID_BITS-1:0]   boost_task;
        logic [PRIO_BITS-1:0] boost_priority;
        logic                 grant_valid;
        logic [ID_BITS-1:0]   grant_task;
    } t_result;

    pim_pkg::t_state      r_state, n_state;
    logic                 r_owner_valid, n_owner_valid;
    logic [ID_BITS-1:0]   r_owner_task, n_owner_task;
    logic [PRIO_BITS-1:0] r_owner_cur, n_owner_cur;
    logic [PRIO_BITS-1:0] r_owner_saved, n_owner_saved;
    logic                 r_owner_boosted, n_owner_boosted;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_k, n_k;
    logic [IDX_W-1:0]     r_last, n_last;
    logic [CNT_W-1:0]     r_addr, n_addr;
    logic                 r_rd_pend, n_rd_pend;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    t_result              r_hold, n_hold;
    t_result              r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [ENT_W-1:0]     w_wdata;
    logic [IDX_W-1:0]     w_raddr;
    logic [ENT_W-1:0]     w_rdata;
    logic [ID_BITS-1:0]   w_rd_id;
    logic [PRIO_BITS-1:0] w_rd_prio;
    logic [CNT_W-1:0]     w_count_m1;
    logic                 w_out_free;

    pim_pkg::t_find_ctl   w_find_ctl;
    logic [IDX_W-1:0]     w_find_idx;
    logic [PRIO_BITS-1:0] w_find_prio;
    logic [IDX_W-1:0]     w_top_idx;
    logic [PRIO_BITS-1:0] w_top_prio;
    logic [PRIO_BITS-1:0] w_next_prio;

    pim_waiter_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WAITERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pim_top_finder #(
        .MAX_WAITERS (MAX_WAITERS),
        .PRIO_BITS   (PRIO_BITS)
    ) u_finder (
        .i_clk       (i_clk),
        .i_ctl       (w_find_ctl),
        .i_idx       (w_find_idx),
        .i_prio      (w_find_prio),
        .o_top_idx   (w_top_idx),
        .o_top_prio  (w_top_prio),
        .o_next_prio (w_next_prio)
    );

    assign w_rd_id    = w_rdata[PRIO_BITS +: ID_BITS];
    assign w_rd_prio  = w_rdata[PRIO_BITS-1:0];
    assign w_count_m1 = r_count - CNT_W'(1);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == pim_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= pim_pkg::S_IDLE;
            r_owner_valid   <= 1'b0;
            r_owner_task    <= '0;
            r_owner_cur     <= '0;
            r_owner_saved   <= '0;
            r_owner_boosted <= 1'b0;
            r_count         <= '0;
            r_rd_pend       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_owner_valid   <= n_owner_valid;
            r_owner_task    <= n_owner_task;
            r_owner_cur     <= n_owner_cur;
            r_owner_saved   <= n_owner_saved;
            r_owner_boosted <= n_owner_boosted;
            r_count         <= n_count;
            r_rd_pend       <= n_rd_pend;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_last   <= n_last;
        r_addr   <= n_addr;
        r_rd_idx <= n_rd_idx;
        r_hold   <= n_hold;
        r_out    <= n_out;
    end

    always_comb begin
        logic    v_emit;
        t_result v_res;

        n_state         = r_state;
        n_owner_valid   = r_owner_valid;
        n_owner_task    = r_owner_task;
        n_owner_cur     = r_owner_cur;
        n_owner_saved   = r_owner_saved;
        n_owner_boosted = r_owner_boosted;
        n_count         = r_count;
        n_k             = r_k;
        n_last          = r_last;
        n_addr          = r_addr;
        n_rd_pend       = 1'b0;
        n_rd_idx        = r_rd_idx;
        n_hold          = r_hold;
        n_out           = r_out;
        n_out_valid     = r_out_valid && !i_out_ready;
        w_we            = 1'b0;
        w_waddr         = '0;
        w_wdata         = '0;
        w_raddr         = '0;
        w_find_ctl      = '0;
        w_find_idx      = '0;
        w_find_prio     = '0;
        v_emit          = 1'b0;
        v_res           = '0;

        unique case (r_state)
            pim_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind) inside
                        pim_pkg::KIND_LOCK, pim_pkg::KIND_TRYLOCK: begin
                            v_emit = 1'b1;
                            if (!r_owner_valid) begin
                                n_owner_valid   = 1'b1;
                                n_owner_task    = i_task_id;
                                n_owner_cur     = i_task_priority;
                                n_owner_boosted = 1'b0;
                                v_res.outcome   = pim_pkg::OUT_ACQUIRED;
                            end else if (i_kind == pim_pkg::KIND_TRYLOCK) begin
                                v_res.outcome = pim_pkg::OUT_TRY_FAILED;
                            end else begin
                                if (r_count < CNT_W'(MAX_WAITERS)) begin
                                    w_we        = 1'b1;
                                    w_waddr     = r_count[IDX_W-1:0];
                                    w_wdata     = {i_task_id, i_task_priority};
                                    w_find_idx  = r_count[IDX_W-1:0];
                                    w_find_prio = i_task_priority;
                                    if (r_count == '0) begin
                                        w_find_ctl.take_any = 1'b1;
                                    end else begin
                                        w_find_ctl.take_max = 1'b1;
                                    end
                                    n_count       = r_count + CNT_W'(1);
                                    v_res.outcome = pim_pkg::OUT_QUEUED;
                                end else begin
                                    v_res.outcome = pim_pkg::OUT_QUEUE_FULL;
                                end
                                // The table is never empty here, so inheritance applies.
                                if (w_next_prio > r_owner_cur) begin
                                    if (!r_owner_boosted) begin
                                        n_owner_saved   = r_owner_cur;
                                        n_owner_boosted = 1'b1;
                                    end
                                    n_owner_cur          = w_next_prio;
                                    v_res.boost_valid    = 1'b1;
                                    v_res.boost_task     = r_owner_task;
                                    v_res.boost_priority = w_next_prio;
                                end
                            end
                        end
                        pim_pkg::KIND_UNLOCK: begin
                            if (r_owner_valid && r_owner_boosted) begin
                                v_res.restore_valid    = 1'b1;
                                v_res.restore_task     = r_owner_task;
                                v_res.restore_priority = r_owner_saved;
                                n_owner_boosted        = 1'b0;
                            end
                            if (r_count == '0) begin
                                n_owner_valid = 1'b0;
                                v_res.outcome = pim_pkg::OUT_FREED;
                                v_emit        = 1'b1;
                            end else begin
                                w_raddr = w_top_idx;
                                n_k     = w_top_idx;
                                n_last  = w_count_m1[IDX_W-1:0];
                                n_hold  = v_res;
                                n_state = pim_pkg::S_GET_LAST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pim_pkg::S_GET_LAST: begin
                // Read data is the top waiter, which becomes the owner.
                n_owner_valid      = 1'b1;
                n_owner_task       = w_rd_id;
                n_owner_cur        = w_top_prio;
                n_hold.outcome     = pim_pkg::OUT_HANDED_OVER;
                n_hold.grant_valid = 1'b1;
                n_hold.grant_task  = w_rd_id;
                w_raddr            = r_last;
                n_state            = pim_pkg::S_REPLACE;
            end
            pim_pkg::S_REPLACE: begin
                // Move the last entry into the freed slot.
                w_we    = 1'b1;
                w_waddr = r_k;
                w_wdata = w_rdata;
                n_count = w_count_m1;
                n_addr  = '0;
                if (w_count_m1 == '0) begin
                    v_emit = 1'b1;
                    v_res  = r_hold;
                end else begin
                    n_state = pim_pkg::S_SCAN;
                end
            end
            pim_pkg::S_SCAN: begin
                if (r_addr < r_count) begin
                    w_raddr   = r_addr[IDX_W-1:0];
                    n_rd_pend = 1'b1;
                    n_rd_idx  = r_addr[IDX_W-1:0];
                    n_addr    = r_addr + CNT_W'(1);
                end else begin
                    n_state = pim_pkg::S_FINISH;
                end
                if (r_rd_pend) begin
                    w_find_idx  = r_rd_idx;
                    w_find_prio = w_rd_prio;
                    if (r_rd_idx == '0) begin
                        w_find_ctl.take_any = 1'b1;
                    end else begin
                        w_find_ctl.take_max = 1'b1;
                    end
                end
            end
            pim_pkg::S_FINISH: begin
                v_emit = 1'b1;
                v_res  = r_hold;
                if (w_top_prio > r_owner_cur) begin
                    if (!r_owner_boosted) begin
                        n_owner_saved   = r_owner_cur;
                        n_owner_boosted = 1'b1;
                    end
                    n_owner_cur          = w_top_prio;
                    v_res.boost_valid    = 1'b1;
                    v_res.boost_task     = r_owner_task;
                    v_res.boost_priority = w_top_prio;
                end
            end
            pim_pkg::S_HOLD: begin
                v_emit = 1'b1;
                v_res  = r_hold;
            end
            default: begin
                n_state = pim_pkg::S_IDLE;
            end
        endcase

        if (v_emit) begin
            if (w_out_free) begin
                n_out       = v_res;
                n_out_valid = 1'b1;
                n_state     = pim_pkg::S_IDLE;
            end else begin
                n_hold  = v_res;
                n_state = pim_pkg::S_HOLD;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_outcome          = r_out.outcome;
    assign o_restore_valid    = r_out.restore_valid;
    assign o_restore_task     = r_out.restore_task;
    assign o_restore_priority = r_out.restore_priority;
    assign o_boost_valid      = r_out.boost_valid;
    assign o_boost_task       = r_out.boost_task;
    assign o_boost_priority   = r_out.boost_priority;
    assign o_grant_valid      = r_out.grant_valid;
    assign o_grant_task       = r_out.grant_task;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WAITERS))
        else $error("waiter count beyond table depth");

    a_boost_has_owner : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owner_boosted |-> r_owner_valid)
        else $error("boosted flag set on a free mutex");

    a_grant_outcome : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_grant_valid) |-> (o_outcome == pim_pkg::OUT_HANDED_OVER))
        else $error("grant reported without handover");

    a_remove_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pim_pkg::S_REPLACE) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("swap-remove did not drop exactly one waiter");

    a_finish_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pim_pkg::S_FINISH) |-> (r_count != '0))
        else $error("inheritance rescan finished on an empty table");

endmodule

// File: sim/priority_inheritance_mutex_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_inheritance_mutex_tb
// Drives lock, trylock and unlock requests into the mutex with random gaps
// and output stalls, predicts each result with its own copy of the owner and
// waiter table, and compares every result field by field in request order.
// ----------------------------------------------------------------------------
module priority_inheritance_mutex_tb;

    localparam int ID_W        = pim_pkg::ID_BITS_DEF;
    localparam int PRIO_W      = pim_pkg::PRIO_BITS_DEF;
    localparam int WAIT_SLOTS  = pim_pkg::MAX_WAITERS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;

    // The one kind code that the block ignores.
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    typedef struct packed {
        pim_pkg::t_outcome outcome;
        logic              restore_valid;
        logic [ID_W-1:0]   restore_task;
        logic [PRIO_W-1:0] restore_priority;
        logic              boost_valid;
        logic [ID_W-1:0]   boost_task;
        logic [PRIO_W-1:0] boost_priority;
        logic              grant_valid;
        logic [ID_W-1:0]   grant_task;
    } t_mutex_result;

    class mutex_scoreboard;
        bit                own_valid;
        bit [ID_W-1:0]     own_task;
        bit [PRIO_W-1:0]   own_prio;
        bit [PRIO_W-1:0]   own_base;
        bit                own_boosted;
        bit [ID_W-1:0]     wait_id[WAIT_SLOTS];
        bit [PRIO_W-1:0]   wait_prio[WAIT_SLOTS];
        int unsigned       held;
        t_mutex_result     expected_q[$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       ignored;
        int unsigned       boosts;
        int unsigned       restores;
        int unsigned       outcome_seen[6];

        function int pending();
            return expected_q.size();
        endfunction

        // Lowest index wins among equal priorities.
        function int top_waiter();
            int best;
            int i;
            best = 0;
            for (i = 1; i < held; i++) begin
                if (wait_prio[i] > wait_prio[best]) best = i;
            end
            return best;
        endfunction

        function void apply_inheritance(inout t_mutex_result r);
            bit [PRIO_W-1:0] top;
            if (!own_valid || held == 0) return;
            top = wait_prio[top_waiter()];
            if (top > own_prio) begin
                if (!own_boosted) begin
                    own_base    = own_prio;
                    own_boosted = 1'b1;
                end
                own_prio         = top;
                r.boost_valid    = 1'b1;
                r.boost_task     = own_task;
                r.boost_priority = top;
            end
        endfunction

        function void note_request(logic [1:0] kind, logic [ID_W-1:0] id,
                                   logic [PRIO_W-1:0] prio);
            t_mutex_result r;
            int k;
            r = '0;
            if (kind == KIND_RESERVED) begin
                ignored++;
                return;
            end
            if (kind == pim_pkg::KIND_LOCK || kind == pim_pkg::KIND_TRYLOCK) begin
                if (!own_valid) begin
                    own_valid   = 1'b1;
                    own_task    = id;
                    own_prio    = prio;
                    own_boosted = 1'b0;
                    r.outcome   = pim_pkg::OUT_ACQUIRED;
                end else if (kind == pim_pkg::KIND_TRYLOCK) begin
                    r.outcome = pim_pkg::OUT_TRY_FAILED;
                end else begin
                    if (held < WAIT_SLOTS) begin
                        wait_id[held]   = id;
                        wait_prio[held] = prio;
                        held++;
                        r.outcome = pim_pkg::OUT_QUEUED;
                    end else begin
                        r.outcome = pim_pkg::OUT_QUEUE_FULL;
                    end
                    apply_inheritance(r);
                end
            end else begin
                // Any caller may unlock; the id is not checked against the owner.
                if (own_valid && own_boosted) begin
                    r.restore_valid    = 1'b1;
                    r.restore_task     = own_task;
                    r.restore_priority = own_base;
                    own_boosted        = 1'b0;
                end
                if (held > 0) begin
                    k            = top_waiter();
                    own_task     = wait_id[k];
                    own_prio     = wait_prio[k];
                    own_valid    = 1'b1;
                    wait_id[k]   = wait_id[held-1];
                    wait_prio[k] = wait_prio[held-1];
                    held--;
                    apply_inheritance(r);
                    r.outcome     = pim_pkg::OUT_HANDED_OVER;
                    r.grant_valid = 1'b1;
                    r.grant_task  = own_task;
                end else begin
                    own_valid = 1'b0;
                    r.outcome = pim_pkg::OUT_FREED;
                end
            end
            outcome_seen[r.outcome]++;
            if (r.boost_valid) boosts++;
            if (r.restore_valid) restores++;
            expected_q.push_back(r);
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            errors++;
            $display("[%0t] MISMATCH %s: got %0h, expected %0h",
                     $time, what, got, want);
        endtask

        task compare_field(string what, logic [7:0] got, logic [7:0] want);
            if (got !== want) report(what, got, want);
        endtask

        task check_result(t_mutex_result got);
            t_mutex_result want;
            if (expected_q.size() == 0) begin
                report("result with no request outstanding, outcome",
                       8'(got.outcome), 8'hxx);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("outcome", 8'(got.outcome), 8'(want.outcome));
            compare_field("restore_valid", 8'(got.restore_valid), 8'(want.restore_valid));
            compare_field("restore_task", got.restore_task, want.restore_task);
            compare_field("restore_priority", got.restore_priority, want.restore_priority);
            compare_field("boost_valid", 8'(got.boost_valid), 8'(want.boost_valid));
            compare_field("boost_task", got.boost_task, want.boost_task);
            compare_field("boost_priority", got.boost_priority, want.boost_priority);
            compare_field("grant_valid", 8'(got.grant_valid), 8'(want.grant_valid));
            compare_field("grant_task", got.grant_task, want.grant_task);
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              o_in_ready;
    logic [1:0]        in_kind;
    logic [ID_W-1:0]   in_task_id;
    logic [PRIO_W-1:0] in_task_priority;
    logic              o_out_valid;
    logic              out_ready;
    logic [2:0]        o_outcome;
    logic              o_restore_valid;
    logic [ID_W-1:0]   o_restore_task;
    logic [PRIO_W-1:0] o_restore_priority;
    logic              o_boost_valid;
    logic [ID_W-1:0]   o_boost_task;
    logic [PRIO_W-1:0] o_boost_priority;
    logic              o_grant_valid;
    logic [ID_W-1:0]   o_grant_task;

    mutex_scoreboard   sb;
    t_mutex_result     seen_result;
    int unsigned       send_idle_pct;
    int unsigned       stall_pct;
    int                hold_left;
    int unsigned       idle_cycles;
    int unsigned       accepted;

    priority_inheritance_mutex i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (in_kind),
        .i_task_id          (in_task_id),
        .i_task_priority    (in_task_priority),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_outcome          (o_outcome),
        .o_restore_valid    (o_restore_valid),
        .o_restore_task     (o_restore_task),
        .o_restore_priority (o_restore_priority),
        .o_boost_valid      (o_boost_valid),
        .o_boost_task       (o_boost_task),
        .o_boost_priority   (o_boost_priority),
        .o_grant_valid      (o_grant_valid),
        .o_grant_task       (o_grant_task)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // A long hold-off, when one is pending, overrides the random stalls.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            seen_result.outcome          = pim_pkg::t_outcome'(o_outcome);
            seen_result.restore_valid    = o_restore_valid;
            seen_result.restore_task     = o_restore_task;
            seen_result.restore_priority = o_restore_priority;
            seen_result.boost_valid      = o_boost_valid;
            seen_result.boost_task       = o_boost_task;
            seen_result.boost_priority   = o_boost_priority;
            seen_result.grant_valid      = o_grant_valid;
            seen_result.grant_task       = o_grant_task;
            sb.check_result(seen_result);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Called just after a falling edge; returns just after a falling edge, once the request is accepted.
    task automatic send_request(logic [1:0] kind, logic [ID_W-1:0] id,
                                logic [PRIO_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        in_kind          <= kind;
        in_task_id       <= id;
        in_task_priority <= prio;
        do @(posedge clk); while (o_in_ready !== 1'b1);
        sb.note_request(kind, id, prio);
        accepted++;
        @(negedge clk);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // Low values come often so that equal priorities show up in the table.
    function automatic logic [PRIO_W-1:0] pick_priority();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25) return PRIO_W'($urandom_range(3));
        if (r < 30) return '0;
        if (r < 35) return '1;
        return PRIO_W'($urandom_range(255));
    endfunction

    // Unlocks mostly come from the owner; lock weight steers the table fill.
    task automatic run_phase(int unsigned n_items, int unsigned lock_pct);
        int unsigned sent;
        int unsigned r;
        logic [1:0] kind;
        logic [ID_W-1:0] id;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 3) kind = KIND_RESERVED;
            else if (r < 3 + lock_pct) kind = pim_pkg::KIND_LOCK;
            else if (r < 15 + lock_pct) kind = pim_pkg::KIND_TRYLOCK;
            else kind = pim_pkg::KIND_UNLOCK;
            id = ID_W'($urandom_range(255));
            if (kind == pim_pkg::KIND_UNLOCK && $urandom_range(99) < 80) id = sb.own_task;
            send_request(kind, id, pick_priority());
            if (kind != KIND_RESERVED) sent++;
        end
    endtask

    initial begin
        int i;
        sb               = new;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_kind          = pim_pkg::KIND_LOCK;
        in_task_id       = '0;
        in_task_priority = '0;
        out_ready        = 1'b0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        hold_left        = 0;
        idle_cycles      = 0;
        accepted         = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: free unlock, try on free and held, ignored kind, boost,
        // tie at the top, full table, foreign unlock with restore and handover.
        send_request(pim_pkg::KIND_UNLOCK, 8'h00, 8'h00);
        send_request(pim_pkg::KIND_TRYLOCK, 8'hFF, 8'h00);
        send_request(pim_pkg::KIND_TRYLOCK, 8'h03, 8'h09);
        send_request(KIND_RESERVED, 8'hFF, 8'hFF);
        send_request(pim_pkg::KIND_LOCK, 8'h00, 8'hFF);
        send_request(pim_pkg::KIND_LOCK, 8'hAA, 8'hFF);
        for (i = 0; i < WAIT_SLOTS - 2; i++)
            send_request(pim_pkg::KIND_LOCK, ID_W'(16 + i), PRIO_W'(i * 17));
        send_request(pim_pkg::KIND_LOCK, 8'h55, 8'hFF);
        send_request(pim_pkg::KIND_UNLOCK, 8'h01, 8'h00);
        send_request(pim_pkg::KIND_LOCK, 8'h07, 8'h80);

        send_idle_pct = 0;  stall_pct = 0;
        run_phase(140, 50);
        send_idle_pct = 53; stall_pct = 0;
        run_phase(130, 40);
        send_idle_pct = 0;  stall_pct = 53;
        run_phase(130, 60);
        send_idle_pct = 6;  stall_pct = 6;
        run_phase(130, 45);

        // The receiver holds off while requests keep coming, so the block
        // backs up and stops taking input; then the sender waits it out.
        send_idle_pct = 0;  stall_pct = 0;
        hold_left = HOLD_CYCLES;
        run_phase(40, 50);
        pause_until_drained();

        send_idle_pct = 53; stall_pct = 53;
        run_phase(80, 35);

        pause_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d results of %0d requests (%0d ignored kinds).",
                 sb.checked, accepted, sb.ignored);
        $write("Acquired %0d, queued %0d, full %0d, try failed %0d, ",
               sb.outcome_seen[pim_pkg::OUT_ACQUIRED],
               sb.outcome_seen[pim_pkg::OUT_QUEUED],
               sb.outcome_seen[pim_pkg::OUT_QUEUE_FULL],
               sb.outcome_seen[pim_pkg::OUT_TRY_FAILED]);
        $display("handed %0d, freed %0d, boosts %0d, restores %0d.",
                 sb.outcome_seen[pim_pkg::OUT_HANDED_OVER],
                 sb.outcome_seen[pim_pkg::OUT_FREED], sb.boosts, sb.restores);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
